/* design/sct_pkg.sv */
// Shared types, constants and fixed-point helpers for the Taylor sine/cosine/tangent block.
package sct_pkg;

  // Port formats.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 24;

  // Internal Q12.36 format.
  localparam int IW    = 48;
  localparam int IFRAC = 36;
  localparam int PW    = 2 * IW;

  localparam logic signed [IW-1:0] IMAX     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [IW-1:0] IMIN     = 48'sh8000_0000_0000;
  localparam logic [IW-1:0]        TWO_PI_Q = 48'h0064_87ED_5111;
  localparam logic signed [IW-1:0] ONE_Q    = 48'sh0010_0000_0000;

  localparam logic signed [DATA_W-1:0] OMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OMIN = 32'sh8000_0000;

  // Divider geometry: cells per cycle and dividend register width.
  localparam int DIV_CELLS = 2;
  localparam int DIV_W     = 74;
  localparam int DIV_CW    = 6;
  localparam logic [DIV_CW-1:0] SMALL_CYC = DIV_CW'(IW / DIV_CELLS);
  localparam logic [DIV_CW-1:0] TAN_CYC   = DIV_CW'(DIV_W / DIV_CELLS);

  // Multiplier slices of the second operand.
  localparam int MUL_SLICE = 16;
  localparam int MUL_STEPS = IW / MUL_SLICE;

  // Configuration register indexes and mode codes.
  localparam logic [7:0] CFG_MODE  = 8'd0;
  localparam logic [7:0] CFG_TERMS = 8'd1;
  localparam logic [1:0] MODE_SIN  = 2'd0;
  localparam logic [1:0] MODE_COS  = 2'd1;

  typedef struct packed {
    logic                   sat;
    logic signed [IW-1:0]   val;
  } qres_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } ores_t;

  // Magnitude of a Q12.36 word; the most negative value maps to 2^47.
  function automatic logic [IW-1:0] mag48(input logic signed [IW-1:0] v);
    mag48 = v[IW-1] ? (~v + 48'd1) : v;
  endfunction

  // Round a 96-bit magnitude product to Q12.36, apply the sign and clamp.
  function automatic qres_t qround(input logic [PW-1:0] p, input logic neg);
    logic [PW:0] s;
    logic [IW:0] q;
    qres_t       r;
    s = {1'b0, p} + ((PW+1)'(1) << (IFRAC - 1));
    if (s[PW:83] != '0) q = (IW+1)'(1) << IW;
    else q = {1'b0, s[83:IFRAC]};
    r.sat = 1'b0;
    r.val = q[IW-1:0];
    if (!neg) begin
      if (q >= ((IW+1)'(1) << (IW - 1))) begin
        r.sat = 1'b1;
        r.val = IMAX;
      end
    end else begin
      if (q > ((IW+1)'(1) << (IW - 1))) begin
        r.sat = 1'b1;
        r.val = IMIN;
      end else begin
        r.val = ~q[IW-1:0] + 48'd1;
      end
    end
    return r;
  endfunction

  // Saturating Q12.36 add.
  function automatic qres_t qadd(input logic signed [IW-1:0] a, input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    qres_t              r;
    s = {a[IW-1], a} + {b[IW-1], b};
    r.sat = 1'b0;
    r.val = s[IW-1:0];
    if (s[IW] != s[IW-1]) begin
      r.sat = 1'b1;
      r.val = s[IW] ? IMIN : IMAX;
    end
    return r;
  endfunction

  // Q12.36 to Q8.24, round half away from zero, then clamp.
  function automatic ores_t to_out(input logic signed [IW-1:0] v);
    logic [IW:0]   s;
    logic [IW-12:0] m;
    ores_t         r;
    s = {1'b0, mag48(v)} + (IW+1)'(1 << (IFRAC - FRAC_W - 1));
    m = s[IW:IFRAC-FRAC_W];
    r.sat = 1'b0;
    r.val = v[IW-1] ? DATA_W'(~m + 1'b1) : DATA_W'(m);
    if (!v[IW-1] && m > (IW-11)'(OMAX)) begin
      r.sat = 1'b1;
      r.val = OMAX;
    end else if (v[IW-1] && m > ((IW-11)'(1) << (DATA_W - 1))) begin
      r.sat = 1'b1;
      r.val = OMIN;
    end
    return r;
  endfunction

endpackage

/* design/sct_cell.sv */
// One restoring-division cell: shifts in a dividend bit and conditionally subtracts.
module sct_cell (
  input  logic [sct_pkg::IW-1:0] rem_in,
  input  logic                   bit_in,
  input  logic [sct_pkg::IW-1:0] divisor,
  output logic [sct_pkg::IW-1:0] rem_out,
  output logic                   q
);
  import sct_pkg::*;

  logic [IW:0] trial;
  logic [IW:0] diff;

  // The partial remainder stays below the divisor, so one subtract suffices.
  assign trial   = {rem_in, bit_in};
  assign diff    = trial - {1'b0, divisor};
  assign q       = (trial >= {1'b0, divisor});
  assign rem_out = q ? diff[IW-1:0] : trial[IW-1:0];

endmodule

/* design/sct_div.sv */
// Iterative divider built from a short chain of division cells.
module sct_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sct_pkg::DIV_W-1:0]  dividend,
  input  logic [sct_pkg::IW-1:0]     divisor,
  input  logic [sct_pkg::DIV_CW-1:0] cycles,
  output logic [sct_pkg::DIV_W-1:0]  quot,
  output logic                       done
);
  import sct_pkg::*;

  logic [IW-1:0]       rem;
  logic [DIV_W-1:0]    shreg;
  logic [IW-1:0]       div_r;
  logic [DIV_CW-1:0]   cnt;
  logic                busy;
  logic [IW-1:0]       rem_c [DIV_CELLS+1];
  logic [DIV_CELLS-1:0] qbits;

  // Chain the cells; each consumes the next dividend bit, MSB first.
  assign rem_c[0] = rem;
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    sct_cell u_cell (
      .rem_in  (rem_c[i]),
      .bit_in  (shreg[DIV_W-1-i]),
      .divisor (div_r),
      .rem_out (rem_c[i+1]),
      .q       (qbits[DIV_CELLS-1-i])
    );
  end

  // Load on start, then run the chain once per cycle for the requested count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= cycles;
        rem   <= '0;
        shreg <= dividend;
        div_r <= divisor;
        quot  <= '0;
      end else if (busy) begin
        rem   <= rem_c[DIV_CELLS];
        shreg <= shreg << DIV_CELLS;
        quot  <= {quot[DIV_W-1-DIV_CELLS:0], qbits};
        cnt   <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/sct_mul.sv */
// Multi-cycle 48 x 48 unsigned multiplier, one 48 x 16 slice per cycle.
module sct_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [sct_pkg::IW-1:0] a,
  input  logic [sct_pkg::IW-1:0] b,
  output logic [sct_pkg::PW-1:0] prod,
  output logic                   done
);
  import sct_pkg::*;

  logic [IW-1:0]          a_r;
  logic [IW-1:0]          b_r;
  logic [1:0]             step;
  logic                   busy;
  logic [IW+MUL_SLICE-1:0] part;
  logic [PW-1:0]          part_sh;

  // Partial product of the current slice, aligned to its weight.
  assign part = a_r * b_r[MUL_SLICE-1:0];
  always_comb begin
    unique case (step)
      2'd0:    part_sh = PW'(part);
      2'd1:    part_sh = PW'(part) << MUL_SLICE;
      default: part_sh = PW'(part) << (2 * MUL_SLICE);
    endcase
  end

  // Accumulate one slice a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        a_r  <= a;
        b_r  <= b;
        prod <= '0;
      end else if (busy) begin
        prod <= prod + part_sh;
        b_r  <= b_r >> MUL_SLICE;
        step <= step + 1'b1;
        if (step == 2'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/sine_cosine_tangent_taylor.sv */
// Top level: Taylor-series sine, cosine and tangent sequencer with config registers.
//
//   channel  direction  handshake                 word
//   angle    in         angle_valid/angle_stall   angle (Q8.24)
//   result   out        result_valid/result_stall value (Q8.24), saturated
//   cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One word at a time. Range reduction subtracts 2*pi until the magnitude is below it, x^2
// uses the multiplier, and each series term is an add step, a 3-slice multiply and a
// two-cell divider run; tangent runs both series and a quotient division.
// Synchronous reset restores function_mode 0 and term_count 8.
// A finished word waits in the output register under stall while the next angle is taken.
module sine_cosine_tangent_taylor #(
  parameter int MAX_TERMS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               angle_valid,
  output logic                               angle_stall,
  input  logic signed [sct_pkg::DATA_W-1:0]  angle,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [sct_pkg::DATA_W-1:0]  value,
  output logic                               saturated,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);
  import sct_pkg::*;

  localparam int NW  = $clog2(MAX_TERMS + 1);
  localparam int DWD = 2 * (NW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_SQ, S_SQW, S_ADD, S_TMULW, S_TDIV, S_TDIVW, S_QDIV, S_QDIVW, S_DONE
  } state_t;

  state_t state;

  logic [1:0]               mode_r;
  logic [5:0]               count_r;
  logic [NW-1:0]            n_max;
  logic [NW-1:0]            n;
  logic [NW-1:0]            terms_eff;
  logic [IW-5:0]            red_mag;
  logic                     red_neg;
  logic signed [IW-1:0]     x2;
  logic signed [IW-1:0]     r;
  logic signed [IW-1:0]     t;
  logic signed [IW-1:0]     sum;
  logic signed [IW-1:0]     s_sum;
  logic signed [IW-1:0]     prodq;
  logic                     mul_neg;
  logic                     cos_pass;
  logic                     sat;
  logic signed [DATA_W-1:0] res_val;
  logic                     res_sat;

  logic                     mul_start;
  logic [IW-1:0]            mul_a;
  logic [IW-1:0]            mul_b;
  logic [PW-1:0]            mul_prod;
  logic                     mul_done;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [IW-1:0]            div_divisor;
  logic [DIV_CW-1:0]        div_cycles;
  logic [DIV_W-1:0]         div_quot;
  logic                     div_done;

  logic [IW-5:0]            wide_mag;
  logic [NW:0]              two_n;
  logic [DWD-1:0]           d;
  qres_t                    qr;
  qres_t                    ad;
  ores_t                    oc;
  logic [IW-1:0]            q48;
  logic [DIV_W:0]           qf;
  logic                     tneg;

  assign cfg_ready   = 1'b1;
  assign angle_stall = (state != S_IDLE);

  // Term count limited to the supported maximum.
  assign terms_eff = ({2'b0, count_r} > 8'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(count_r);

  // Magnitude of the angle widened to Q12.36.
  assign wide_mag = angle[DATA_W-1] ? (IW-4)'(~{angle, 12'b0} + 1'b1) : (IW-4)'({angle, 12'b0});

  // Series denominator for the current term.
  assign two_n = {n, 1'b0};
  assign d = cos_pass ? DWD'((DWD'(two_n) - 1'b1) * DWD'(two_n))
                      : DWD'(DWD'(two_n) * (DWD'(two_n) + 1'b1));

  // Shared arithmetic results.
  assign qr   = qround(mul_prod, mul_neg);
  assign ad   = qadd(sum, t);
  assign oc   = to_out(sum);
  assign q48  = div_quot[IW-1:0];
  assign qf   = ({1'b0, div_quot} + 1'b1) >> 1;
  assign tneg = s_sum[IW-1] ^ sum[IW-1];

  // Operand selection for the multiplier and divider.
  always_comb begin
    mul_start = (state == S_SQ) || (state == S_ADD);
    mul_a     = (state == S_SQ) ? mag48(r) : mag48(t);
    mul_b     = (state == S_SQ) ? mag48(r) : mag48(x2);
    div_start = (state == S_TDIV) || (state == S_QDIV);
    if (state == S_QDIV) begin
      div_dividend = {1'b0, mag48(s_sum), 25'b0};
      div_divisor  = mag48(sum);
      div_cycles   = TAN_CYC;
    end else begin
      div_dividend = {mag48(prodq) + IW'(d >> 1), 26'b0};
      div_divisor  = IW'(d);
      div_cycles   = SMALL_CYC;
    end
  end

  sct_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  sct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .cycles   (div_cycles),
    .quot     (div_quot),
    .done     (div_done)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode_r       <= MODE_SIN;
      count_r      <= 6'd8;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) mode_r <= cfg_data[1:0];
        else if (cfg_index == CFG_TERMS) count_r <= cfg_data[5:0];
      end
      // A taken word clears the output unless a new word replaces it in the same cycle.
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (angle_valid) begin
            red_mag <= wide_mag;
            red_neg <= angle[DATA_W-1];
            n_max   <= terms_eff;
            sat     <= 1'b0;
            if (terms_eff == '0) begin
              res_val <= '0;
              res_sat <= 1'b0;
              state   <= S_DONE;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (red_mag >= (IW-4)'(TWO_PI_Q)) begin
            red_mag <= red_mag - (IW-4)'(TWO_PI_Q);
          end else begin
            r     <= red_neg ? -IW'(red_mag) : IW'(red_mag);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          mul_neg <= 1'b0;
          state   <= S_SQW;
        end
        S_SQW: begin
          if (mul_done) begin
            x2       <= qr.val;
            sat      <= sat | qr.sat;
            cos_pass <= (mode_r == MODE_COS);
            n        <= NW'(1);
            sum      <= '0;
            t        <= (mode_r == MODE_COS) ? ONE_Q : r;
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          sum     <= ad.val;
          sat     <= sat | ad.sat;
          mul_neg <= t[IW-1] ^ x2[IW-1];
          state   <= S_TMULW;
        end
        S_TMULW: begin
          if (mul_done) begin
            prodq <= qr.val;
            sat   <= sat | qr.sat;
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          state <= S_TDIVW;
        end
        S_TDIVW: begin
          if (div_done) begin
            if (n != n_max) begin
              t     <= prodq[IW-1] ? q48 : (~q48 + 48'd1);
              n     <= n + 1'b1;
              state <= S_ADD;
            end else if (mode_r == MODE_SIN || mode_r == MODE_COS) begin
              res_val <= oc.val;
              res_sat <= sat | oc.sat;
              state   <= S_DONE;
            end else if (!cos_pass) begin
              s_sum    <= sum;
              cos_pass <= 1'b1;
              n        <= NW'(1);
              sum      <= '0;
              t        <= ONE_Q;
              state    <= S_ADD;
            end else if (sum == '0) begin
              res_val <= s_sum[IW-1] ? OMIN : OMAX;
              res_sat <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_QDIV;
            end
          end
        end
        S_QDIV: begin
          state <= S_QDIVW;
        end
        S_QDIVW: begin
          if (div_done) begin
            // Integer part beyond the output range saturates outright.
            if (div_quot[DIV_W-1:25] > 49'd128) begin
              res_val <= tneg ? OMIN : OMAX;
              res_sat <= 1'b1;
            end else if (!tneg && qf[DATA_W:0] > (DATA_W+1)'(OMAX)) begin
              res_val <= OMAX;
              res_sat <= 1'b1;
            end else if (tneg && qf[DATA_W:0] > ((DATA_W+1)'(1) << (DATA_W - 1))) begin
              res_val <= OMIN;
              res_sat <= 1'b1;
            end else begin
              res_val <= tneg ? DATA_W'(~qf[DATA_W-1:0] + 1'b1) : qf[DATA_W-1:0];
              res_sat <= sat;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            value        <= res_val;
            saturated    <= res_sat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_sine_cosine_tangent_taylor.sv */
// Self-checking testbench for the Taylor-series sine, cosine and tangent block.
`timescale 1ns / 1ps

module tb_sine_cosine_tangent_taylor;
  import sct_pkg::*;

  // Expected result word.
  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } trig_word_t;

  // Holds the expected words and predicts them from its own copy of the registers.
  class trig_scoreboard;
    logic [1:0]       mode;
    logic [5:0]       terms;
    trig_word_t       pending_words[$];
    int unsigned      checked;

    function new();
      mode  = MODE_SIN;
      terms = 6'd8;
      checked = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] data);
      if (idx == CFG_MODE) mode = data[1:0];
      else if (idx == CFG_TERMS) terms = data[5:0];
    endfunction

    function longint clamp_q(longint v, inout bit sat);
      if (v > 64'sh7FFF_FFFF_FFFF) begin
        sat = 1;
        return 64'sh7FFF_FFFF_FFFF;
      end
      if (v < -64'sh8000_0000_0000) begin
        sat = 1;
        return -64'sh8000_0000_0000;
      end
      return v;
    endfunction

    function longint unsigned abs_q(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Q12.36 product rounded half away from zero.
    function longint mul_q(longint a, longint b, inout bit sat);
      logic [127:0] p;
      longint       q;
      p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
      p = p + (128'd1 << 35);
      if (p >= (128'd1 << 83)) q = 64'sd1 <<< 48;
      else q = longint'(p >> 36);
      if ((a < 0) != (b < 0)) q = -q;
      return clamp_q(q, sat);
    endfunction

    function longint div_term(longint v, longint unsigned d);
      longint unsigned m;
      m = (abs_q(v) + d / 2) / d;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint series_sum(longint r, bit cosine, int n_terms, inout bit sat);
      longint          x2;
      longint          sum;
      longint          t;
      longint unsigned d;
      x2 = mul_q(r, r, sat);
      sum = 0;
      t = cosine ? (64'sd1 <<< 36) : r;
      for (int n = 1; n <= n_terms; n++) begin
        d = cosine ? longint'((2 * n - 1) * (2 * n)) : longint'((2 * n) * (2 * n + 1));
        sum = clamp_q(sum + t, sat);
        t = -div_term(mul_q(t, x2, sat), d);
      end
      return sum;
    endfunction

    function longint narrow_out(longint v, inout bit sat);
      longint o;
      o = longint'((abs_q(v) + 64'd2048) >> 12);
      if (v < 0) o = -o;
      if (o > 64'sh7FFF_FFFF) begin
        sat = 1;
        return 64'sh7FFF_FFFF;
      end
      if (o < -64'sh8000_0000) begin
        sat = 1;
        return -64'sh8000_0000;
      end
      return o;
    endfunction

    function longint tan_quotient(longint s, longint c, inout bit sat);
      bit              neg;
      longint unsigned us, uc, ip, rem, q;
      longint          o;
      neg = (s < 0) != (c < 0);
      us = abs_q(s);
      uc = abs_q(c);
      if (uc == 0) begin
        sat = 1;
        return s < 0 ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      end
      ip = us / uc;
      if (ip > 128) begin
        sat = 1;
        return neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
      end
      rem = us - ip * uc;
      q = ip;
      for (int i = 0; i <= FRAC_W; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= uc) begin
          rem = rem - uc;
          q = q | 1;
        end
      end
      q = (q + 1) >> 1;
      o = neg ? -longint'(q) : longint'(q);
      if (o > 64'sh7FFF_FFFF) begin
        sat = 1;
        return 64'sh7FFF_FFFF;
      end
      if (o < -64'sh8000_0000) begin
        sat = 1;
        return -64'sh8000_0000;
      end
      return o;
    endfunction

    // Predicts the word for one accepted angle.
    function void note_angle(logic signed [DATA_W-1:0] ang);
      longint     wide, r, v, s, c;
      int         n_terms;
      bit         sat;
      trig_word_t w;
      wide = longint'(ang) * 4096;
      r = wide % 64'sh64_87ED_5111;
      n_terms = terms > 32 ? 32 : int'(terms);
      sat = 0;
      if (n_terms == 0) v = 0;
      else if (mode == MODE_SIN) v = narrow_out(series_sum(r, 0, n_terms, sat), sat);
      else if (mode == MODE_COS) v = narrow_out(series_sum(r, 1, n_terms, sat), sat);
      else begin
        s = series_sum(r, 0, n_terms, sat);
        c = series_sum(r, 1, n_terms, sat);
        v = tan_quotient(s, c, sat);
      end
      w.val = v[DATA_W-1:0];
      w.sat = sat;
      pending_words.push_back(w);
    endfunction

    // Returns 0 on a match; a message describes any mismatch.
    function bit check_word(logic signed [DATA_W-1:0] val, logic sat, output string msg);
      trig_word_t w;
      msg = "";
      if (pending_words.size() == 0) begin
        msg = $sformatf("unexpected result word value=%h saturated=%b", val, sat);
        return 1;
      end
      w = pending_words.pop_front();
      checked++;
      if (val !== w.val || sat !== w.sat) begin
        msg = $sformatf("word %0d: value=%h saturated=%b, expected value=%h saturated=%b",
                        checked, val, sat, w.val, w.sat);
        return 1;
      end
      return 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     angle_valid;
  logic                     angle_stall;
  logic signed [DATA_W-1:0] angle;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [DATA_W-1:0] value;
  logic                     saturated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [7:0]               cfg_index;
  logic [7:0]               cfg_data;

  trig_scoreboard sb;
  int             error_count;
  int unsigned    cycle_count;
  int unsigned    angles_sent;
  int unsigned    cfg_writes;
  bit             hold_request;
  bit             run_done;

  sine_cosine_tangent_taylor u_dut (
    .clk         (clk),
    .rst         (rst),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value       (value),
    .saturated   (saturated),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: checks each accepted word and stalls on its own pattern.
  int unsigned stall_mode_left;
  int unsigned stall_mode;
  int unsigned long_hold_left;
  always @(posedge clk) begin
    string msg;
    if (!rst && result_valid && !result_stall) begin
      if (sb.check_word(value, saturated, msg)) report_mismatch(msg);
    end
    if (hold_request && long_hold_left == 0) begin
      hold_request <= 1'b0;
      long_hold_left <= 3000;
    end
    if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode_left <= $urandom_range(20, 300);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Writes one configuration register.
  task automatic write_cfg(logic [7:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // Offers one angle word and holds it until it is taken.
  task automatic send_angle(logic signed [DATA_W-1:0] a);
    angle_valid <= 1'b1;
    angle       <= a;
    do @(posedge clk); while (angle_stall);
    sb.note_angle(a);
    angles_sent++;
  endtask

  function automatic logic signed [DATA_W-1:0] random_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0C90_FDAA)) - 32'sh0648_7ED5;
      2: return 32'sh0192_1FB5 + $signed($urandom_range(0, 64)) - 32;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // Sends a burst of random angles, then sometimes idles for a random gap.
  task automatic send_burst(int count);
    for (int i = 0; i < count; i++) send_angle(random_angle());
    if ($urandom_range(0, 3) != 0) begin
      angle_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Waits until every expected word is in, then idles for the settle count.
  task automatic drain(int settle);
    angle_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [7:0] t;
    logic [1:0] m;
    sb = new();
    error_count = 0;
    cycle_count = 0;
    angles_sent = 0;
    cfg_writes = 0;
    hold_request = 0;
    run_done = 0;
    stall_mode_left = 0;
    stall_mode = 0;
    long_hold_left = 0;
    rst = 1'b1;
    angle_valid = 1'b0;
    angle = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes and a full turn.
    send_angle(32'sh0000_0000);
    send_angle(32'sh7FFF_FFFF);
    send_angle(32'sh8000_0000);
    send_angle(32'sh0648_7ED5);
    send_angle(-32'sh0648_7ED5);
    send_angle(32'sh0192_1FB5);
    drain(50);

    // Directed: cosine, tangent near a pole, mode three, zero and clamped term counts.
    write_cfg(CFG_MODE, 8'd1);
    write_cfg(CFG_TERMS, 8'd1);
    send_angle(32'sh0100_0000);
    send_angle(32'sh8000_0000);
    drain(50);
    write_cfg(CFG_MODE, 8'd2);
    write_cfg(CFG_TERMS, 8'd2);
    send_angle(32'sh016A_09E6);
    send_angle(-32'sh016A_09E6);
    send_angle(32'sh0192_1FB5);
    drain(50);
    write_cfg(CFG_TERMS, 8'd32);
    send_angle(32'sh0192_1FB5);
    send_angle(-32'sh0192_1FB4);
    send_angle(32'sh7FFF_FFFF);
    drain(50);
    write_cfg(CFG_MODE, 8'hFF);
    write_cfg(CFG_TERMS, 8'hFF);
    send_angle(32'sh0080_0000);
    drain(50);
    write_cfg(CFG_TERMS, 8'd0);
    send_angle(32'sh0123_4567);
    send_angle(32'sh8000_0000);
    drain(50);
    write_cfg(CFG_MODE, 8'd0);
    write_cfg(8'd2, 8'($urandom()));
    write_cfg(8'hFF, 8'($urandom()));
    send_angle(32'sh0100_0000);
    drain(50);

    // Random phases: mostly short series, a few long ones, random register writes.
    hold_request = 1;
    for (int ph = 0; ph < 26; ph++) begin
      m = 2'($urandom_range(0, 3));
      if (ph % 7 == 6) t = 8'($urandom_range(32, 63));
      else if (ph % 5 == 4) t = 0;
      else t = 8'($urandom_range(1, 10));
      write_cfg(CFG_MODE, {6'($urandom_range(0, 63)), m});
      write_cfg(CFG_TERMS, {2'($urandom_range(0, 3)), t[5:0]});
      if (ph == 3) hold_request = 1;
      for (int n = 0; n < ((ph % 7 == 6) ? 8 : 22); n += 4) send_burst($urandom_range(1, 4));
      drain(50);
    end

    drain(200);
    $display("run covered %0d angles and %0d register writes across all modes", angles_sent,
             cfg_writes);
    $display("%0d result words checked, %0d mismatches", sb.checked, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
